// ===== rtl/teq_pkg.sv =====
// Package for the timed event queue: payload structs, status and kind codes,
// controller/datapath command and status structs. No dependencies.
package teq_pkg;

    localparam int EVENT_DEPTH   = 64;
    localparam int TRIGGER_DEPTH = 16;
    localparam int EV_CNT_W      = $clog2(EVENT_DEPTH + 1);
    localparam int TR_CNT_W      = $clog2(TRIGGER_DEPTH + 1);
    localparam int TR_IDX_W      = (TRIGGER_DEPTH > 1) ? $clog2(TRIGGER_DEPTH) : 1;

    localparam logic [2:0] KIND_SCHEDULE   = 3'd0;
    localparam logic [2:0] KIND_PUSH       = 3'd1;
    localparam logic [2:0] KIND_CANCEL     = 3'd2;
    localparam logic [2:0] KIND_RESCHEDULE = 3'd3;
    localparam logic [2:0] KIND_POP        = 3'd4;

    localparam logic [2:0] ST_ACCEPTED    = 3'd0;
    localparam logic [2:0] ST_PAST_END    = 3'd1;
    localparam logic [2:0] ST_BEFORE_NOW  = 3'd2;
    localparam logic [2:0] ST_FULL        = 3'd3;
    localparam logic [2:0] ST_TRIGGER     = 3'd4;
    localparam logic [2:0] ST_EVENT       = 3'd5;
    localparam logic [2:0] ST_EMPTY       = 3'd6;
    localparam logic [2:0] ST_CANCEL_MISS = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  source_id;
        logic [7:0]  trigger_id;
        logic [63:0] when_time;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  fired_id;
        logic [63:0] fired_time;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch the input beat
        logic cancel;     // remove earliest entry of the latched source
        logic execute;    // schedule / push / pop and build the result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_cancel;  // latched op is cancel or reschedule
        logic needs_exec;    // latched op still needs execute
        logic has_result;    // latched kind produces a result
    } dp_stat_t;

endpackage

// ===== rtl/teq_ctrl.sv =====
// Controller of the timed event queue: sequences capture, cancel and execute.
// Depends on teq_pkg.
module teq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              res_load,
    input  logic              res_free,
    input  teq_pkg::dp_stat_t stat,
    output teq_pkg::dp_cmd_t  cmd
);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CANCEL = 2'd1;
    localparam logic [1:0] S_EXEC   = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        res_load    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CANCEL;
                end
            end
            S_CANCEL: begin
                if (stat.needs_cancel) cmd.cancel = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (!stat.has_result) begin
                    state_next = S_IDLE;
                end else if (res_free) begin
                    cmd.execute = 1'b1;
                    res_load    = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        if (aresetn) begin
            assert (!(cmd.cancel && cmd.execute))
                else $error("cancel and execute in same cycle");
        end
    end

    a_load_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> stat.has_result) else $error("result without kind");
    a_capture_next_cancel: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == S_CANCEL)) else $error("bad sequence");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !res_load) else $error("ready during execute");
endmodule

// ===== rtl/teq_datapath.sv =====
// Datapath of the timed event queue: shift-register sorted store, trigger stack,
// current time and end time. Depends on teq_pkg.
module teq_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  teq_pkg::in_item_t  in_item,
    input  logic               cfg_we,
    input  logic [63:0]        cfg_data,
    input  teq_pkg::dp_cmd_t   cmd,
    output teq_pkg::dp_stat_t  stat,
    output teq_pkg::out_item_t result
);
    localparam int ED = teq_pkg::EVENT_DEPTH;
    localparam int TD = teq_pkg::TRIGGER_DEPTH;

    teq_pkg::in_item_t op_reg;
    logic [63:0] end_time_reg;
    logic [63:0] now_reg;
    logic [63:0] times_reg [ED];
    logic [7:0]  srcs_reg  [ED];
    logic [teq_pkg::EV_CNT_W-1:0] ecnt_reg;
    logic [7:0]  tstack_reg [TD];
    logic [teq_pkg::TR_CNT_W-1:0] tcnt_reg;

    // per-cell compare vectors
    logic [ED-1:0] valid_v, match_v, first_m, le_v, ins_before;
    logic any_match;

    always_comb begin
        for (int i = 0; i < ED; i++) begin
            valid_v[i] = (i < int'(ecnt_reg));
            match_v[i] = valid_v[i] && (srcs_reg[i] == op_reg.source_id);
            le_v[i]    = valid_v[i] && (times_reg[i] <= op_reg.when_time);
        end
        // first match: isolate lowest set bit
        first_m    = match_v & (~match_v + 1'b1);
        any_match  = |match_v;
        ins_before = ~le_v;   // cells at or after insert position (sorted)
    end

    logic sch_op;
    logic [2:0] sch_status;
    logic [teq_pkg::TR_IDX_W-1:0] tpos, ttop;
    assign sch_op = (op_reg.kind == teq_pkg::KIND_SCHEDULE)
                 || (op_reg.kind == teq_pkg::KIND_RESCHEDULE);
    assign tpos = teq_pkg::TR_IDX_W'(tcnt_reg);
    assign ttop = teq_pkg::TR_IDX_W'(tcnt_reg - 1'b1);

    always_comb begin
        if (op_reg.when_time < now_reg)                    sch_status = teq_pkg::ST_BEFORE_NOW;
        else if (end_time_reg != '0 && op_reg.when_time >= end_time_reg)
                                                           sch_status = teq_pkg::ST_PAST_END;
        else if (int'(ecnt_reg) >= ED)                     sch_status = teq_pkg::ST_FULL;
        else                                               sch_status = teq_pkg::ST_ACCEPTED;
    end

    assign stat.needs_cancel = (op_reg.kind == teq_pkg::KIND_CANCEL)
                            || (op_reg.kind == teq_pkg::KIND_RESCHEDULE);
    assign stat.needs_exec   = stat.has_result;
    assign stat.has_result   = (op_reg.kind <= teq_pkg::KIND_POP);

    logic cancel_hit_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) op_reg <= in_item;
        if (cfg_we) end_time_reg <= cfg_data;
        if (!aresetn) end_time_reg <= '0;
    end

    // event store: shift cells; cancel shifts down past the hit, schedule shifts up
    always_ff @(posedge aclk) begin
        if (cmd.cancel && any_match) begin
            for (int i = 0; i < ED; i++) begin
                logic past;
                past = |(first_m & ((ED)'(1) << i | (((ED)'(1) << i) - 1'b1)));
                if (past && i + 1 < ED) begin
                    times_reg[i] <= times_reg[(i + 1 < ED) ? i + 1 : i];
                    srcs_reg[i]  <= srcs_reg[(i + 1 < ED) ? i + 1 : i];
                end
            end
        end else if (cmd.execute && sch_op && sch_status == teq_pkg::ST_ACCEPTED) begin
            for (int i = 0; i < ED; i++) begin
                if (ins_before[i]) begin
                    if (i == 0 || !ins_before[(i > 0) ? i - 1 : 0]) begin
                        times_reg[i] <= op_reg.when_time;
                        srcs_reg[i]  <= op_reg.source_id;
                    end else begin
                        times_reg[i] <= times_reg[(i > 0) ? i - 1 : 0];
                        srcs_reg[i]  <= srcs_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end
        end else if (cmd.execute && op_reg.kind == teq_pkg::KIND_POP && tcnt_reg == '0
                     && ecnt_reg != '0) begin
            for (int i = 0; i + 1 < ED; i++) begin
                times_reg[i] <= times_reg[i + 1];
                srcs_reg[i]  <= srcs_reg[i + 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cancel) cancel_hit_reg <= any_match;
        if (cmd.execute && op_reg.kind == teq_pkg::KIND_PUSH && int'(tcnt_reg) < TD)
            tstack_reg[tpos] <= op_reg.trigger_id;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ecnt_reg <= '0;
            tcnt_reg <= '0;
            now_reg  <= '0;
        end else if (cmd.cancel && any_match) begin
            ecnt_reg <= ecnt_reg - 1'b1;
        end else if (cmd.execute) begin
            case (op_reg.kind)
                teq_pkg::KIND_SCHEDULE, teq_pkg::KIND_RESCHEDULE: begin
                    if (sch_status == teq_pkg::ST_ACCEPTED) ecnt_reg <= ecnt_reg + 1'b1;
                end
                teq_pkg::KIND_PUSH: begin
                    if (int'(tcnt_reg) < TD) tcnt_reg <= tcnt_reg + 1'b1;
                end
                teq_pkg::KIND_POP: begin
                    if (tcnt_reg != '0) begin
                        tcnt_reg <= tcnt_reg - 1'b1;
                    end else if (ecnt_reg != '0) begin
                        ecnt_reg <= ecnt_reg - 1'b1;
                        now_reg  <= times_reg[0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        result.fired_id   = '0;
        result.fired_time = now_reg;
        case (op_reg.kind)
            teq_pkg::KIND_SCHEDULE, teq_pkg::KIND_RESCHEDULE: result.status = sch_status;
            teq_pkg::KIND_PUSH:
                result.status = (int'(tcnt_reg) < TD) ? teq_pkg::ST_ACCEPTED : teq_pkg::ST_FULL;
            teq_pkg::KIND_CANCEL:
                result.status = cancel_hit_reg ? teq_pkg::ST_ACCEPTED : teq_pkg::ST_CANCEL_MISS;
            teq_pkg::KIND_POP: begin
                if (tcnt_reg != '0) begin
                    result.status   = teq_pkg::ST_TRIGGER;
                    result.fired_id = tstack_reg[ttop];
                end else if (ecnt_reg != '0) begin
                    result.status     = teq_pkg::ST_EVENT;
                    result.fired_id   = srcs_reg[0];
                    result.fired_time = times_reg[0];
                end else begin
                    result.status = teq_pkg::ST_EMPTY;
                end
            end
            default: result.status = teq_pkg::ST_ACCEPTED;
        endcase
    end

    a_ecnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(ecnt_reg) <= ED) else $error("event count overflow");
    a_tcnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(tcnt_reg) <= TD) else $error("trigger count overflow");
    a_now_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> now_reg >= $past(now_reg)) else $error("time went backwards");
endmodule

// ===== rtl/timed_event_queue_with_triggers_unit.sv =====
// Top level of the timed event queue with triggers.
// Depends on teq_pkg, teq_ctrl and teq_datapath.
//
// Usage:
//   s_ channel: one beat is one operation (schedule, push trigger, cancel,
//   reschedule, pop). m_ channel: one result beat per operation of kind 0-4;
//   kinds 5-7 are swallowed with no result.
//   cfg channel: writes end_time; write only while the block is idle.
// Sequence: an operation is captured in S_IDLE, the cancel search runs in
//   S_CANCEL and the store update plus result load in S_EXEC. s_ready is high
//   only in S_IDLE, so a new beat waits until the last one is through. The
//   shift-register store compares all cells in parallel, one shift per update.
// Stall: the result sits in an output register; a new beat is still taken
//   while it waits, and the next result waits in S_EXEC until m_ready frees
//   the register.
// Reset: aresetn (synchronous, active low) empties both stores, clears current
//   time and end_time; store contents are not cleared.
module timed_event_queue_with_triggers_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  teq_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output teq_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [63:0]        cfg_data
);
    teq_pkg::dp_cmd_t   cmd;
    teq_pkg::dp_stat_t  stat;
    teq_pkg::out_item_t result;
    logic res_load, res_free;
    logic m_valid_reg;
    teq_pkg::out_item_t m_data_reg;

    // output register frees when empty or being drained
    assign res_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    teq_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready,
        .res_load, .res_free, .stat, .cmd
    );

    teq_datapath u_dp (
        .aclk, .aresetn,
        .in_item (s_data),
        .cfg_we  (cfg_valid),
        .cfg_data,
        .cmd, .stat, .result
    );

    // hold result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_load) m_data_reg <= result;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> res_free) else $error("result overwrite");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("beat dropped");
    a_one_res: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> !res_load) else $error("double result");
endmodule

// ===== tb/tb_teq_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the timed event queue: watches the operation, result and
// end_time write channels, predicts each result and compares. Depends on teq_pkg.
module tb_teq_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  teq_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  teq_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [63:0]        cfg_data,
    output int                 error_count,
    output int                 pending_count,
    output int                 result_count
);
    import teq_pkg::*;

    logic [63:0] limit_time;
    logic [63:0] now_time;
    logic [63:0] ev_time [$];
    logic [7:0]  ev_src [$];
    logic [7:0]  trig_stack [$];
    out_item_t   expected_results [$];

    function automatic bit drop_earliest(input logic [7:0] src);
        for (int i = 0; i < ev_src.size(); i++) begin
            if (ev_src[i] == src) begin
                ev_src.delete(i);
                ev_time.delete(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [2:0] insert_event(input logic [7:0] src,
                                                 input logic [63:0] t);
        int pos;
        pos = 0;
        if (t < now_time) return ST_BEFORE_NOW;
        if (limit_time != 0 && t >= limit_time) return ST_PAST_END;
        if (ev_src.size() >= EVENT_DEPTH) return ST_FULL;
        // equal times keep arrival order
        while (pos < ev_time.size() && ev_time[pos] <= t) pos++;
        ev_time.insert(pos, t);
        ev_src.insert(pos, src);
        return ST_ACCEPTED;
    endfunction

    task automatic predict_op(input in_item_t op);
        out_item_t r;
        r = '0;
        case (op.kind)
            KIND_SCHEDULE: r.status = insert_event(op.source_id, op.when_time);
            KIND_PUSH: begin
                if (trig_stack.size() >= TRIGGER_DEPTH) r.status = ST_FULL;
                else begin
                    trig_stack.insert(trig_stack.size(), op.trigger_id);
                    r.status = ST_ACCEPTED;
                end
            end
            KIND_CANCEL:
                r.status = drop_earliest(op.source_id) ? ST_ACCEPTED : ST_CANCEL_MISS;
            KIND_RESCHEDULE: begin
                void'(drop_earliest(op.source_id));
                r.status = insert_event(op.source_id, op.when_time);
            end
            KIND_POP: begin
                if (trig_stack.size() > 0) begin
                    r.fired_id = trig_stack[trig_stack.size() - 1];
                    trig_stack.delete(trig_stack.size() - 1);
                    r.status = ST_TRIGGER;
                end else if (ev_src.size() > 0) begin
                    r.fired_id = ev_src.pop_front();
                    now_time = ev_time.pop_front();
                    r.status = ST_EVENT;
                end else r.status = ST_EMPTY;
            end
            default: return;  // unknown kinds are swallowed
        endcase
        r.fired_time = now_time;
        expected_results.insert(expected_results.size(), r);
    endtask

    always @(posedge aclk) begin
        out_item_t e;
        if (!aresetn) begin
            limit_time = '0;
            now_time = '0;
            ev_time.delete();
            ev_src.delete();
            trig_stack.delete();
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) limit_time = cfg_data;
            if (s_valid && s_ready) predict_op(s_data);
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected: %p", m_data);
                    error_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_data.status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, m_data.status);
                        error_count++;
                    end
                    if (m_data.fired_id !== e.fired_id) begin
                        $error("fired_id: expected %0d, got %0d",
                               e.fired_id, m_data.fired_id);
                        error_count++;
                    end
                    if (m_data.fired_time !== e.fired_time) begin
                        $error("fired_time: expected %0d, got %0d",
                               e.fired_time, m_data.fired_time);
                        error_count++;
                    end
                end
            end
        end
        pending_count = expected_results.size();
    end

    initial begin
        error_count = 0;
        pending_count = 0;
        result_count = 0;
    end
endmodule

// ===== tb/tb_timed_event_queue_with_triggers_unit.sv =====
`timescale 1ns / 1ps
// Top of the timed event queue testbench: clock, reset, operation and
// end_time stimulus, verdict. Depends on teq_pkg, tb_teq_checker and the RTL.
module tb_timed_event_queue_with_triggers_unit;
    import teq_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [63:0] cfg_data = '0;
    int          error_count, pending_count, result_count;
    bit          calm_phase;    // no idling on either side
    logic [63:0] time_base;     // keeps random times near the current time
    int          op_count;

    localparam int RANDOM_OPS = 1700;

    always #2 aclk = ~aclk;

    timed_event_queue_with_triggers_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    tb_teq_checker u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .error_count(error_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    // Stall the result side at random, except in the calm phase.
    always @(posedge aclk) begin
        m_ready <= calm_phase || ($urandom_range(99) >= 13);
    end

    // Send one operation beat; hold valid and payload until accepted.
    // Wait for a clock edge first so valid is never dropped and raised in one step;
    // the block is not ready again that soon anyway.
    task automatic send_op(input logic [2:0] kind, input logic [7:0] src,
                           input logic [7:0] trig, input logic [63:0] t);
        @(posedge aclk);
        if (!calm_phase && $urandom_range(99) < 13) begin
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{kind: kind, source_id: src, trigger_id: trig, when_time: t};
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
        op_count++;
    endtask

    // Drain all results, let swallowed kinds settle, then write end_time.
    task automatic write_end_time(input logic [63:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_count != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // Random times: mostly close to the base so that order and ties matter.
    function automatic logic [63:0] pick_time();
        case ($urandom_range(9))
            0: return {$urandom, $urandom};
            1: return time_base - $urandom_range(3);
            2: return '1;
            default: return time_base + $urandom_range(40);
        endcase
    endfunction

    task automatic random_phase(input int n, input int pop_weight);
        logic [2:0] k;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 30) k = KIND_SCHEDULE;
            else if (r < 40) k = KIND_PUSH;
            else if (r < 48) k = KIND_CANCEL;
            else if (r < 56) k = KIND_RESCHEDULE;
            else if (r < 56 + pop_weight) k = KIND_POP;
            else if (r < 97) k = KIND_SCHEDULE;
            else k = 3'($urandom_range(7, 5));   // noise, swallowed
            // few sources so cancels often hit
            send_op(k, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15)),
                    8'($urandom), pick_time());
            if (k == KIND_POP) time_base = time_base + $urandom_range(8);
        end
    endtask

    initial begin
        calm_phase = 1'b0;
        time_base = '0;
        op_count = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty pop, field extremes, ties, cancel miss, triggers.
        send_op(KIND_POP, 8'h00, 8'h00, 64'd0);
        send_op(KIND_CANCEL, 8'hFF, 8'h00, 64'd0);
        send_op(KIND_SCHEDULE, 8'hFF, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(KIND_SCHEDULE, 8'h01, 8'h00, 64'd10);
        send_op(KIND_SCHEDULE, 8'h02, 8'h00, 64'd10);
        send_op(KIND_SCHEDULE, 8'h00, 8'h00, 64'd5);
        send_op(KIND_PUSH, 8'h00, 8'hFF, 64'd0);
        send_op(KIND_PUSH, 8'h00, 8'h00, 64'd0);
        send_op(KIND_POP, 8'h00, 8'h00, 64'd0);
        send_op(KIND_POP, 8'h00, 8'h00, 64'd0);
        send_op(KIND_RESCHEDULE, 8'h02, 8'h00, 64'd3);
        send_op(KIND_CANCEL, 8'h01, 8'h00, 64'd0);
        send_op(KIND_POP, 8'h00, 8'h00, 64'd0);
        send_op(KIND_SCHEDULE, 8'h07, 8'h00, 64'd1);    // before now
        send_op(KIND_RESCHEDULE, 8'h09, 8'h00, 64'd1);  // miss, then refused
        send_op(3'd7, 8'h00, 8'h00, 64'd0);
        send_op(3'd5, 8'hAA, 8'h55, 64'd0);
        for (int i = 0; i < 17; i++) send_op(KIND_PUSH, 8'h00, 8'(i), 64'd0);
        for (int i = 0; i < 17; i++) send_op(KIND_POP, 8'h00, 8'h00, 64'd0);

        // End time set: past-end drop at and above the limit.
        write_end_time(64'd100);
        send_op(KIND_SCHEDULE, 8'h03, 8'h00, 64'd100);
        send_op(KIND_SCHEDULE, 8'h04, 8'h00, 64'd99);
        // Fill the store to overflow, then empty it.
        for (int i = 0; i < 66; i++) send_op(KIND_SCHEDULE, 8'(i), 8'h00, 64'd50);
        for (int i = 0; i < 66; i++) send_op(KIND_POP, 8'h00, 8'h00, 64'd0);
        write_end_time(64'hFFFF_FFFF_FFFF_FFFF);
        time_base = 64'd50;

        // Random: build-up heavy, then pop heavy, calm stretch, near-all-ones base.
        random_phase(500, 10);
        wait_idle();    // sender holds off until everything is back
        random_phase(300, 40);
        calm_phase = 1'b1;
        random_phase(300, 25);
        calm_phase = 1'b0;
        write_end_time(time_base + 64'd30);
        random_phase(300, 25);
        write_end_time(64'd0);
        time_base = 64'hFFFF_FFFF_FFFF_FF00;
        random_phase(300, 25);

        wait_idle();
        repeat (20) @(posedge aclk);
        $display("Ran %0d operation beats (%0d results) over 4 end_time settings,",
                 op_count, result_count);
        $display("covering triggers, ties, cancels, refusals and both store overflows.");
        if (error_count == 0 && pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
